@@ rtl/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants for the peak finder with dead time.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int TICK_BITS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int DEAD_TIME_BITS  = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int QUEUE_DEPTH     = 4;

    localparam int THRESHOLD_RESET = 800;
    localparam int DEAD_TIME_RESET = 192;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEAD_TIME = 2'd1;

endpackage

@@ rtl/pfd_front.sv @@
// ----------------------------------------------------------------------------
// pfd_front
// Sample intake, configuration registers and peak classification.
// ----------------------------------------------------------------------------
module pfd_front
    import pfd_pkg::*;
#(
    parameter int TICK_BITS   = TICK_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CFG_BITS    = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_BITS-1:0]           i_cfg_data,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_req,
    output logic                          o_push,
    output logic [TICK_BITS-1:0]          o_tick,
    output logic signed [SAMPLE_BITS-1:0] o_amp,
    output logic                          o_replace
);

    localparam int GAP_BITS = (TICK_BITS > DEAD_TIME_BITS) ? TICK_BITS : DEAD_TIME_BITS;

    logic signed [SAMPLE_BITS-1:0]   r_threshold;
    logic [DEAD_TIME_BITS-1:0]       r_dead_time;

    logic signed [SAMPLE_BITS-1:0]   r_older,     n_older;
    logic signed [SAMPLE_BITS-1:0]   r_middle,    n_middle;
    logic [1:0]                      r_seen,      n_seen;
    logic [TICK_BITS-1:0]            r_tick,      n_tick;
    logic                            r_have_peak, n_have_peak;
    logic [TICK_BITS-1:0]            r_cur_tick,  n_cur_tick;
    logic signed [SAMPLE_BITS-1:0]   r_cur_amp,   n_cur_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= SAMPLE_BITS'(THRESHOLD_RESET);
            r_dead_time <= DEAD_TIME_BITS'(DEAD_TIME_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_DEAD_TIME: r_dead_time <= i_cfg_data[DEAD_TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older     <= '0;
            r_middle    <= '0;
            r_seen      <= '0;
            r_tick      <= '0;
            r_have_peak <= 1'b0;
            r_cur_tick  <= '0;
            r_cur_amp   <= '0;
        end else begin
            r_older     <= n_older;
            r_middle    <= n_middle;
            r_seen      <= n_seen;
            r_tick      <= n_tick;
            r_have_peak <= n_have_peak;
            r_cur_tick  <= n_cur_tick;
            r_cur_amp   <= n_cur_amp;
        end
    end

    always_comb begin
        logic signed [SAMPLE_BITS-1:0] older, middle, cur_amp;
        logic [1:0]                    seen;
        logic [TICK_BITS-1:0]          tick, tick_inc, cur_tick, gap;
        logic                          have_peak;

        older     = r_older;
        middle    = r_middle;
        seen      = r_seen;
        tick      = r_tick;
        have_peak = r_have_peak;
        cur_tick  = r_cur_tick;
        cur_amp   = r_cur_amp;

        if (i_start_req) begin
            older     = '0;
            middle    = '0;
            seen      = '0;
            tick      = '0;
            have_peak = 1'b0;
            cur_tick  = '0;
            cur_amp   = '0;
        end

        tick_inc = (tick == {TICK_BITS{1'b1}}) ? tick : tick + TICK_BITS'(1);
        gap      = tick - cur_tick;

        n_older     = r_older;
        n_middle    = r_middle;
        n_seen      = r_seen;
        n_tick      = r_tick;
        n_have_peak = r_have_peak;
        n_cur_tick  = r_cur_tick;
        n_cur_amp   = r_cur_amp;
        o_push      = 1'b0;
        o_tick      = tick;
        o_amp       = middle;
        o_replace   = 1'b0;

        if (i_accept) begin
            n_have_peak = have_peak;
            n_cur_tick  = cur_tick;
            n_cur_amp   = cur_amp;
            case (seen)
                2'd0: begin
                    n_older  = older;
                    n_middle = i_sample;
                    n_tick   = '0;
                    n_seen   = 2'd1;
                end
                default: begin
                    if (seen != 2'd1 && middle >= r_threshold && middle > older &&
                        middle <= i_sample) begin
                        if (!have_peak || GAP_BITS'(gap) > GAP_BITS'(r_dead_time)) begin
                            o_push    = 1'b1;
                            o_replace = 1'b0;
                        end else if (middle > cur_amp) begin
                            o_push    = 1'b1;
                            o_replace = 1'b1;
                        end
                        if (o_push) begin
                            n_have_peak = 1'b1;
                            n_cur_tick  = tick;
                            n_cur_amp   = middle;
                        end
                    end
                    n_older  = middle;
                    n_middle = i_sample;
                    n_tick   = tick_inc;
                    n_seen   = 2'd2;
                end
            endcase
        end
    end

    a_peak_above_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_amp >= r_threshold)
        else $error("peak below threshold");

    a_replace_needs_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_replace) |-> (r_have_peak && !i_start_req))
        else $error("replacement without a current peak");

    a_push_records_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_have_peak && r_cur_tick == $past(o_tick) && r_cur_amp == $past(o_amp)))
        else $error("emitted peak not recorded");

endmodule

@@ rtl/pfd_queue.sv @@
// ----------------------------------------------------------------------------
// pfd_queue
// Short result queue between classification and the result port.
// ----------------------------------------------------------------------------
module pfd_queue
    import pfd_pkg::*;
#(
    parameter int WIDTH = 33,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [WIDTH-1:0]    r_head;
    logic                r_head_valid;
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                push_ok;
    logic                pop_ok;
    logic                head_load;
    logic                mem_rd;
    logic                mem_wr;

    assign o_full    = (r_count == CNT_BITS'(DEPTH));
    assign o_empty   = !r_head_valid;
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_pop && r_head_valid;
    assign head_load = !r_head_valid || pop_ok;
    assign mem_rd    = head_load && (r_count != '0);
    assign mem_wr    = push_ok && !(head_load && (r_count == '0));
    assign o_data    = r_head;

    // head register takes the oldest stored entry, else the incoming transfer
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (mem_rd) begin
            r_head <= r_mem[r_rd_ptr];
        end else if (head_load && push_ok) begin
            r_head <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (head_load) begin
                r_head_valid <= mem_rd || push_ok;
            end
            if (mem_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
            end
            if (mem_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
            end
            case ({mem_wr, mem_rd})
                2'b10:   r_count <= r_count + CNT_BITS'(1);
                2'b01:   r_count <= r_count - CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue count overrun");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("transfer into a full queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr && !mem_rd) |=> r_count == $past(r_count) + CNT_BITS'(1))
        else $error("queue count lost a transfer");

    a_head_when_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_head_valid)
        else $error("stored entry behind an empty head");

endmodule

@@ rtl/peak_finder_with_dead_time_unit.sv @@
// ----------------------------------------------------------------------------
// peak_finder_with_dead_time_unit
// Threshold peak detector with one-sample look-ahead and dead-time merging.
//
//   channel  | transfer when             | carries
//   ---------+---------------------------+----------------------------------
//   input    | i_push && !o_full         | i_sample, i_start_req
//   result   | i_pop && !o_empty         | o_peak_tick, o_peak_amplitude,
//            |                           | o_replace_last
//   config   | i_cfg_valid (ready = 1)   | i_cfg_index, i_cfg_data
//
// One sample transfer per cycle unless o_full; results leave at one per cycle.
// A held sample is classified at the transfer of the sample after it; with an
// empty queue its result is on the result ports from the next cycle.
// The result path holds QUEUE_DEPTH + 1 entries; o_full stalls the input only
// while all are taken, whether or not the next sample would give a peak.
// Reset is synchronous; no clearing pass, the block is ready straight after.
// ----------------------------------------------------------------------------
module peak_finder_with_dead_time_unit
    import pfd_pkg::*;
#(
    parameter  int TICK_BITS   = TICK_BITS_DEF,
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CFG_BITS    = (SAMPLE_BITS > DEAD_TIME_BITS) ? SAMPLE_BITS : DEAD_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_BITS-1:0]           i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_req,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [TICK_BITS-1:0]          o_peak_tick,
    output logic signed [SAMPLE_BITS-1:0] o_peak_amplitude,
    output logic                          o_replace_last
);

    localparam int Q_WIDTH = TICK_BITS + SAMPLE_BITS + 1;

    logic                          accept;
    logic                          push;
    logic [TICK_BITS-1:0]          tick;
    logic signed [SAMPLE_BITS-1:0] amp;
    logic                          replace;
    logic [Q_WIDTH-1:0]            q_out;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !o_full;

    pfd_front #(
        .TICK_BITS   (TICK_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_start_req (i_start_req),
        .o_push      (push),
        .o_tick      (tick),
        .o_amp       (amp),
        .o_replace   (replace)
    );

    pfd_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({tick, amp, replace}),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (q_out)
    );

    assign o_peak_tick      = q_out[Q_WIDTH-1 -: TICK_BITS];
    assign o_peak_amplitude = q_out[SAMPLE_BITS:1];
    assign o_replace_last   = q_out[0];

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for peak_finder_with_dead_time_unit: directed cases for
// waveform start, waveform edges, threshold limits and dead-time merging,
// then random pulse trains and noise under varied back-pressure.
// A local model predicts every peak; results are checked in order.
// ----------------------------------------------------------------------------
module tb;
    import pfd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [15:0]        tick;
        logic signed [15:0] amp;
        logic               replace;
    } peak_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [15:0]               i_cfg_data;
    logic                      i_push;
    logic                      o_full;
    logic signed [15:0]        i_sample;
    logic                      i_start_req;
    logic                      o_empty;
    logic                      i_pop;
    logic [15:0]               o_peak_tick;
    logic signed [15:0]        o_peak_amplitude;
    logic                      o_replace_last;

    peak_finder_with_dead_time_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_sample         (i_sample),
        .i_start_req      (i_start_req),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_peak_tick      (o_peak_tick),
        .o_peak_amplitude (o_peak_amplitude),
        .o_replace_last   (o_replace_last)
    );

    // detector model state
    logic signed [15:0] cfg_threshold = 16'(THRESHOLD_RESET);
    logic [15:0]        cfg_dead_time = 16'(DEAD_TIME_RESET);
    logic signed [15:0] prev_sample;
    logic signed [15:0] held_sample;
    logic [1:0]         held_count;
    logic [15:0]        held_tick;
    logic               peak_found;
    logic [15:0]        last_peak_tick;
    logic signed [15:0] last_peak_amp;

    peak_t pending_peaks[$];
    peak_t want;
    int    mismatches = 0;
    int    sent_count = 0;
    int    cycles = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_pop <= ($urandom_range(99) >= stall_pct);
    end

    task automatic clear_waveform;
        prev_sample    = '0;
        held_sample    = '0;
        held_count     = '0;
        held_tick      = '0;
        peak_found     = 1'b0;
        last_peak_tick = '0;
        last_peak_amp  = '0;
    endtask

    task automatic detect_peak(input logic signed [15:0] x, input logic st);
        peak_t       p;
        logic [15:0] gap;
        if (st)
            clear_waveform();
        if (held_count == 2'd0) begin
            held_sample = x;
            held_tick   = '0;
            held_count  = 2'd1;
        end else begin
            if (held_count != 2'd1 && held_sample >= cfg_threshold &&
                held_sample > prev_sample && held_sample <= x) begin
                gap = held_tick - last_peak_tick;
                if (!peak_found || gap > cfg_dead_time || held_sample > last_peak_amp) begin
                    p.tick    = held_tick;
                    p.amp     = held_sample;
                    p.replace = peak_found && gap <= cfg_dead_time;
                    pending_peaks = {pending_peaks, p};
                    peak_found     = 1'b1;
                    last_peak_tick = held_tick;
                    last_peak_amp  = held_sample;
                end
            end
            prev_sample = held_sample;
            held_sample = x;
            held_tick   = (held_tick == 16'hFFFF) ? held_tick : held_tick + 16'd1;
            held_count  = 2'd2;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (pending_peaks.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected peak, expected none, actual tick %0d amp %0d",
                             $time, o_peak_tick, o_peak_amplitude);
                end else begin
                    want = pending_peaks.pop_front();
                    if (o_peak_tick !== want.tick) begin
                        mismatches++;
                        $display("%0t: peak_tick expected %0d actual %0d",
                                 $time, want.tick, o_peak_tick);
                    end
                    if (o_peak_amplitude !== want.amp) begin
                        mismatches++;
                        $display("%0t: peak_amplitude expected %0d actual %0d",
                                 $time, want.amp, o_peak_amplitude);
                    end
                    if (o_replace_last !== want.replace) begin
                        mismatches++;
                        $display("%0t: replace_last expected %0b actual %0b",
                                 $time, want.replace, o_replace_last);
                    end
                end
            end
            if (i_push && !o_full)
                detect_peak(i_sample, i_start_req);
        end
    end

    task automatic send_sample(input logic signed [15:0] s, input logic st);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_push   <= 1'b0;
            i_sample <= 16'($urandom);
            @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_sample    <= s;
        i_start_req <= st;
        do @(posedge i_clk); while (o_full);
        sent_count++;
    endtask

    task automatic wait_idle;
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_THRESHOLD)
            cfg_threshold = val;
        else if (idx == CFG_DEAD_TIME)
            cfg_dead_time = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic signed [15:0] thr, input logic [15:0] dead);
        wait_idle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_DEAD_TIME, dead);
    endtask

    // baseline noise with triangular pulses, plateaus from repeated values
    task automatic send_waveform(input int len);
        int base, h, w, pos, v, prev;
        base = int'($urandom_range(200)) - 100;
        pos  = -1;
        prev = 0;
        for (int k = 0; k < len; k++) begin
            if (pos < 0 && $urandom_range(99) < 20) begin
                h   = int'($urandom_range(40000, 100));
                w   = int'($urandom_range(5, 1));
                pos = 0;
            end
            v = base + int'($urandom_range(60)) - 30;
            if (pos >= 0) begin
                v += h * (w - ((pos > w) ? pos - w : w - pos)) / w;
                pos++;
                if (pos > 2 * w)
                    pos = -1;
            end
            if (k > 0 && $urandom_range(99) < 10)
                v = prev;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            send_sample(16'(v), k == 0);
            prev = v;
        end
    endtask

    task automatic random_traffic(input int n_items);
        int target, burst;
        target = sent_count + n_items;
        while (sent_count < target) begin
            if ($urandom_range(99) < 85) begin
                send_waveform(int'($urandom_range(40, 3)));
            end else begin
                burst = int'($urandom_range(8, 1));
                repeat (burst) send_sample(16'($urandom_range(16'hFFFF)), $urandom_range(3) == 0);
            end
        end
    endtask

    // no start after reset: samples form a waveform from tick 0
    task automatic test_power_up;
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd900, 1'b0);
        send_sample(16'sd900, 1'b0);
        send_sample(16'sd100, 1'b0);
    endtask

    // a start drops the held sample untested
    task automatic test_start_mid_waveform;
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd3000, 1'b0);
        send_sample(16'sd5000, 1'b1);
        send_sample(16'sd6000, 1'b0);
        send_sample(16'sd6000, 1'b0);
        send_sample(16'sd0, 1'b0);
    endtask

    task automatic test_threshold_limits;
        set_config(16'sh8000, 16'd0);
        send_sample(16'sh8000, 1'b1);
        send_sample(-16'sd32767, 1'b0);
        send_sample(-16'sd32767, 1'b0);
        set_config(16'sh7FFF, 16'd0);
        send_sample(16'sd32766, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
    endtask

    task automatic test_dead_time_merge;
        set_config(16'sd100, 16'd3);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd200, 1'b0);
        send_sample(16'sd200, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd300, 1'b0);
        send_sample(16'sd300, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd250, 1'b0);
        send_sample(16'sd250, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd400, 1'b0);
        send_sample(16'sd400, 1'b0);
    endtask

    task automatic run_phase(input int idle, input int stall,
                             input logic signed [15:0] thr, input logic [15:0] dead);
        set_config(thr, dead);
        idle_pct  = idle;
        stall_pct = stall;
        random_traffic(192);
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic test_random_traffic;
        run_phase(0, 0, 16'sd800, 16'd192);
        run_phase(69, 0, 16'(int'($urandom_range(1700)) - 200), 16'($urandom_range(20)));
        run_phase(0, 69, 16'sh8000, 16'hFFFF);
        run_phase(32, 32, 16'sh7FFF, 16'd0);
        run_phase(32, 32, 16'(int'($urandom_range(1700)) - 200), 16'($urandom_range(10)));
        run_phase(0, 0, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_push      = 1'b0;
        i_sample    = '0;
        i_start_req = 1'b0;
        i_pop       = 1'b0;
        clear_waveform();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up();
        test_start_mid_waveform();
        test_threshold_limits();
        test_dead_time_merge();
        test_random_traffic();
        wait_idle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pfd_pkg.sv
rtl/pfd_front.sv
rtl/pfd_queue.sv
rtl/peak_finder_with_dead_time_unit.sv
test/tb.sv
